FILE: src/assert_macros.svh
// Assertion macros for the translator RTL, included by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: src/nsat_pkg.sv
// Types and codes of the NUMA segment address translator.
`default_nettype none
package nsat_pkg;
    typedef enum logic [2:0] {
        OP_INSERT      = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_ADDR_TO_IDX = 3'd2,
        OP_IDX_TO_ADDR = 3'd3,
        OP_IS_LOCAL    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_RANGE   = 2'd3
    } t_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] seg_base;
        logic [47:0] seg_length;
        logic [3:0]  seg_node;
        logic        seg_enabled;
        logic        seg_hotplug;
        logic [47:0] phys_addr;
        logic [3:0]  target_node;
        logic [35:0] page_index;
        logic [4:0]  page_shift;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_node;
        logic [35:0] index_result;
        logic [47:0] addr_result;
        logic        is_local;
        logic [4:0]  node_count;
        logic [6:0]  segment_count;
    } t_out;

    typedef struct packed {
        logic [47:0] seg_start;
        logic [47:0] seg_end;
        logic [3:0]  node;
    } t_seg;

    typedef struct packed {
        logic load;
        logic ev;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic pre_fin;
        logic ev_fin;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

FILE: src/nsat_ctrl.sv
// Sequencer of the translator: accept, table walk, result hand-off.
`default_nettype none
module nsat_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  nsat_pkg::t_sts  i_sts,
    output nsat_pkg::t_cmd  o_cmd
);
    import nsat_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.pre_fin ? S_FIN : S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                o_cmd.ev = 1'b1;
                n_state  = i_sts.ev_fin ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/nsat_dp.sv
// Datapath of the translator: segment memory, walk registers, result register.
`default_nettype none
`include "assert_macros.svh"
module nsat_dp #(
    parameter int MAX_SEGMENTS = 64,
    parameter int NODE_LIMIT   = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  nsat_pkg::t_cmd  i_cmd,
    output nsat_pkg::t_sts  o_sts,
    input  nsat_pkg::t_in   i_in_data,
    input  wire             i_out_stall,
    output logic            o_out_valid,
    output nsat_pkg::t_out  o_out_data,
    input  wire             i_cfg_valid,
    input  wire             i_cfg_data
);
    import nsat_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    t_seg        r_mem [MAX_SEGMENTS];
    t_seg        r_rd;
    logic        we;
    t_seg        wd;
    logic [AW-1:0] ra;

    logic [2:0]  r_op, n_op;
    logic [47:0] r_base, n_base, r_end, n_end, r_pa, n_pa;
    logic [3:0]  r_node, n_node, r_tn, n_tn, r_last, n_last, r_fnode, n_fnode;
    logic [4:0]  r_shift, n_shift, r_nodes, n_nodes;
    logic [CW-1:0] r_idx, n_idx, r_count, n_count;
    logic [63:0] r_off, n_off;
    logic        r_have, n_have, r_local, n_local, r_hp, n_hp;
    logic [1:0]  r_status, n_status;
    logic [35:0] r_index, n_index;
    logic [47:0] r_addr, n_addr;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic [47:0] size;
    logic [63:0] base_off, acc, acc_sh;
    logic [66:0] wide_off;
    logic        last;
    logic        ins_ok;

    assign ra = (r_op == OP_INSERT) ? AW'(r_idx - CW'(1)) : r_idx[AW-1:0];

    assign size     = r_rd.seg_end - r_rd.seg_start + 48'd1;
    assign wide_off = {31'd0, i_in_data.page_index} << i_in_data.page_shift;
    assign last     = ((r_idx + CW'(1)) == r_count);
    assign base_off = (!r_have || (r_last != r_rd.node)) ? 64'd0 : r_off;
    assign acc      = base_off + {16'd0, r_pa - r_rd.seg_start};
    assign acc_sh   = acc >> r_shift;
    assign ins_ok   = i_in_data.seg_enabled && (i_in_data.seg_length != 48'd0)
                      && !(i_in_data.seg_hotplug && !r_hp)
                      && (r_count < CW'(MAX_SEGMENTS))
                      && ({5'd0, i_in_data.seg_node} < 9'(NODE_LIMIT));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_idx[AW-1:0]] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    // status to the controller, from input data, output stall and registers only
    always_comb begin
        o_sts = '0;
        o_sts.out_busy = r_out_valid && i_out_stall;
        unique case (i_in_data.operation)
            OP_INSERT:      o_sts.pre_fin = !ins_ok;
            OP_CLEAR:       o_sts.pre_fin = 1'b1;
            OP_ADDR_TO_IDX: o_sts.pre_fin = (r_count == '0);
            OP_IDX_TO_ADDR: o_sts.pre_fin = (|wide_off[66:64]) || (r_count == '0);
            OP_IS_LOCAL:    o_sts.pre_fin = (r_count == '0);
            default:        o_sts.pre_fin = 1'b1;
        endcase
        unique case (r_op)
            OP_INSERT:      o_sts.ev_fin = (r_idx == '0) || (r_rd.seg_start < r_base);
            OP_ADDR_TO_IDX: o_sts.ev_fin = !(r_pa > r_rd.seg_end) || last;
            OP_IDX_TO_ADDR: o_sts.ev_fin = ((r_rd.node == r_tn) && (r_off < {16'd0, size}))
                                           || last;
            OP_IS_LOCAL:    o_sts.ev_fin = (r_rd.seg_start <= r_pa && r_pa <= r_rd.seg_end)
                                           || last;
            default:        o_sts.ev_fin = 1'b1;
        endcase
    end

    always_comb begin
        n_op = r_op; n_base = r_base; n_end = r_end; n_pa = r_pa;
        n_node = r_node; n_tn = r_tn; n_last = r_last; n_fnode = r_fnode;
        n_shift = r_shift; n_nodes = r_nodes; n_idx = r_idx; n_count = r_count;
        n_off = r_off; n_have = r_have; n_local = r_local; n_hp = r_hp;
        n_status = r_status; n_index = r_index; n_addr = r_addr;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we = 1'b0;
        wd = r_rd;

        if (i_cfg_valid) begin
            n_hp = i_cfg_data;
        end

        if (i_cmd.load) begin
            n_op = i_in_data.operation;
            n_base = i_in_data.seg_base;
            n_end = i_in_data.seg_base + i_in_data.seg_length - 48'd1;
            n_node = i_in_data.seg_node;
            n_pa = i_in_data.phys_addr;
            n_tn = i_in_data.target_node;
            n_shift = i_in_data.page_shift;
            n_have = 1'b0;
            n_fnode = '0;
            n_index = '0;
            n_addr = '0;
            n_local = 1'b0;
            n_idx = '0;
            n_off = '0;
            unique case (i_in_data.operation)
                OP_INSERT: begin
                    priority if (!i_in_data.seg_enabled || i_in_data.seg_length == 48'd0) begin
                        n_status = STAT_IGNORED;
                    end else if (i_in_data.seg_hotplug && !r_hp) begin
                        n_status = STAT_IGNORED;
                    end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                        n_status = STAT_FULL;
                    end else if ({5'd0, i_in_data.seg_node} >= 9'(NODE_LIMIT)) begin
                        n_status = STAT_RANGE;
                    end else begin
                        n_status = STAT_OK;
                        n_idx = r_count;
                        if ({1'b0, i_in_data.seg_node} >= r_nodes) begin
                            n_nodes = {1'b0, i_in_data.seg_node} + 5'd1;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                    n_status = STAT_OK;
                end
                OP_ADDR_TO_IDX: begin
                    n_status = STAT_RANGE;
                end
                OP_IDX_TO_ADDR: begin
                    n_status = STAT_RANGE;
                    n_off = wide_off[63:0];
                end
                OP_IS_LOCAL: begin
                    n_status = STAT_OK;
                end
                default: begin
                    n_status = STAT_IGNORED;
                end
            endcase
        end else if (i_cmd.ev) begin
            n_idx = r_idx + CW'(1);
            unique case (r_op)
                OP_INSERT: begin
                    we = 1'b1;
                    if (r_idx == '0 || r_rd.seg_start < r_base) begin
                        wd = '{seg_start: r_base, seg_end: r_end, node: r_node};
                        n_count = r_count + CW'(1);
                        n_idx = r_idx;
                    end else begin
                        n_idx = r_idx - CW'(1);
                    end
                end
                OP_ADDR_TO_IDX: begin
                    n_have = 1'b1;
                    n_last = r_rd.node;
                    if (r_pa > r_rd.seg_end) begin
                        n_off = base_off + {16'd0, size};
                    end else if (r_pa >= r_rd.seg_start) begin
                        if (acc_sh[63:36] == '0) begin
                            n_status = STAT_OK;
                            n_index = acc_sh[35:0];
                            n_fnode = r_rd.node;
                        end
                    end
                end
                OP_IDX_TO_ADDR: begin
                    if (r_rd.node == r_tn) begin
                        if (r_off >= {16'd0, size}) begin
                            n_off = r_off - {16'd0, size};
                        end else begin
                            n_addr = r_rd.seg_start + r_off[47:0];
                            n_status = STAT_OK;
                        end
                    end
                end
                OP_IS_LOCAL: begin
                    if (r_rd.seg_start <= r_pa && r_pa <= r_rd.seg_end) begin
                        n_local = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.fin) begin
            n_out_valid = 1'b1;
            n_out.status = r_status;
            n_out.found_node = r_fnode;
            n_out.index_result = r_index;
            n_out.addr_result = r_addr;
            n_out.is_local = r_local;
            n_out.node_count = r_nodes;
            n_out.segment_count = 7'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_nodes <= '0;
            r_hp <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_nodes <= n_nodes;
            r_hp <= n_hp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_base <= n_base; r_end <= n_end; r_pa <= n_pa;
        r_node <= n_node; r_tn <= n_tn; r_last <= n_last; r_fnode <= n_fnode;
        r_shift <= n_shift; r_idx <= n_idx; r_off <= n_off; r_have <= n_have;
        r_local <= n_local; r_status <= n_status; r_index <= n_index;
        r_addr <= n_addr; r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(MAX_SEGMENTS), "segment count past table depth")
    `ASSERT_ALWAYS(a_write_insert, !we || (r_op == OP_INSERT), "table written outside insert")
    `ASSERT_IMPLY(a_fin_valid, i_cmd.fin, r_out_valid, "finished result not presented")
    `ASSERT_ALWAYS(a_nodes_bound, r_nodes <= 5'd16, "node count out of range")
endmodule
`default_nettype wire

FILE: src/numa_segment_address_translator.sv
// Clear, rejected insert, index overflow or lookup on an empty table go straight to finish;
// else each entry walked passes read and evaluate. Insert walks from the table end down to
// its slot; lookups from entry 0 to the deciding entry or the last one. One operation at a
// time, one memory port. Result is held in an output register; the next transfer is taken
// while it waits. Reset clears segment count, node count and result valid, sets
// hotplug_allowed to 1; table contents are not cleared.
`default_nettype none
module numa_segment_address_translator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int NODE_LIMIT   = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  nsat_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output nsat_pkg::t_out  o_out_data,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire             i_cfg_data
);
    import nsat_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    nsat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nsat_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .NODE_LIMIT   (NODE_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );
endmodule
`default_nettype wire

FILE: verif/numa_segment_address_translator_test.sv
// Self-checking testbench for the NUMA segment address translator.
`timescale 1ns / 1ps
`default_nettype none
module numa_segment_address_translator_test;
    import nsat_pkg::*;

    localparam int MAX_SEGS = 64;
    localparam int NODE_LIM = 16;
    localparam logic [47:0] TOP48 = 48'hFFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 3000000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_stall;
    t_out  o_out_data;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    logic  i_cfg_data;

    int     errors;
    longint cycles;
    bit     quiet;

    numa_segment_address_translator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    class segment_table_scoreboard;
        logic [47:0] seg_start [MAX_SEGS];
        logic [47:0] seg_end   [MAX_SEGS];
        logic [3:0]  seg_owner [MAX_SEGS];
        int          used;
        logic [4:0]  nodes;
        bit          hotplug_ok;
        t_out        pending [$];

        function new();
            used = 0;
            nodes = 0;
            hotplug_ok = 1;
        endfunction

        function logic [47:0] size_of(int i);
            return seg_end[i] - seg_start[i] + 48'd1;
        endfunction

        function logic [1:0] insert(t_in it);
            int pos;
            if (!it.seg_enabled || it.seg_length == 0) return STAT_IGNORED;
            if (it.seg_hotplug && !hotplug_ok) return STAT_IGNORED;
            if (used >= MAX_SEGS) return STAT_FULL;
            if (it.seg_node >= NODE_LIM) return STAT_RANGE;
            if ({1'b0, it.seg_node} >= nodes) nodes = it.seg_node + 5'd1;
            pos = 0;
            for (int i = used; i > 0; i--)
                if (seg_start[i-1] < it.seg_base) begin
                    pos = i;
                    break;
                end
            for (int i = used; i > pos; i--) begin
                seg_start[i] = seg_start[i-1];
                seg_end[i]   = seg_end[i-1];
                seg_owner[i] = seg_owner[i-1];
            end
            seg_start[pos] = it.seg_base;
            seg_end[pos]   = it.seg_base + it.seg_length - 48'd1;
            seg_owner[pos] = it.seg_node;
            used++;
            return STAT_OK;
        endfunction

        function void note_transfer(t_in it);
            t_out r;
            logic [63:0] off;
            logic [3:0]  last;
            bit          have;
            r = '0;
            r.status = STAT_IGNORED;
            case (it.operation)
                OP_INSERT: r.status = insert(it);
                OP_CLEAR: begin
                    used = 0;
                    r.status = STAT_OK;
                end
                OP_ADDR_TO_IDX: begin
                    r.status = STAT_RANGE;
                    off = 0;
                    have = 0;
                    last = 0;
                    for (int i = 0; i < used; i++) begin
                        if (!have || last != seg_owner[i]) begin
                            off = 0;
                            last = seg_owner[i];
                            have = 1;
                        end
                        if (it.phys_addr > seg_end[i]) begin
                            off += size_of(i);
                            continue;
                        end
                        if (it.phys_addr < seg_start[i]) break;
                        off += it.phys_addr - seg_start[i];
                        off >>= it.page_shift;
                        if (off <= 64'hF_FFFF_FFFF) begin
                            r.status = STAT_OK;
                            r.index_result = off[35:0];
                            r.found_node = seg_owner[i];
                        end
                        break;
                    end
                end
                OP_IDX_TO_ADDR: begin
                    r.status = STAT_RANGE;
                    if (it.page_shift == 0 ||
                        (64'(it.page_index) >> (64 - it.page_shift)) == 0) begin
                        off = 64'(it.page_index) << it.page_shift;
                        for (int i = 0; i < used; i++) begin
                            if (seg_owner[i] != it.target_node) continue;
                            if (off >= 64'(size_of(i))) begin
                                off -= size_of(i);
                                continue;
                            end
                            r.addr_result = seg_start[i] + off[47:0];
                            r.status = STAT_OK;
                            break;
                        end
                    end
                end
                OP_IS_LOCAL: begin
                    r.status = STAT_OK;
                    for (int i = 0; i < used; i++)
                        if (seg_start[i] <= it.phys_addr && it.phys_addr <= seg_end[i]) begin
                            r.is_local = 1;
                            break;
                        end
                end
                default: ;
            endcase
            r.node_count = nodes;
            r.segment_count = 7'(used);
            pending.push_back(r);
        endfunction

        task check_result(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                report("unexpected transfer", got[63:0], 64'd0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.found_node !== w.found_node) report("found_node", got.found_node, w.found_node);
            if (got.index_result !== w.index_result)
                report("index_result", got.index_result, w.index_result);
            if (got.addr_result !== w.addr_result)
                report("addr_result", got.addr_result, w.addr_result);
            if (got.is_local !== w.is_local) report("is_local", got.is_local, w.is_local);
            if (got.node_count !== w.node_count) report("node_count", got.node_count, w.node_count);
            if (got.segment_count !== w.segment_count)
                report("segment_count", got.segment_count, w.segment_count);
        endtask
    endclass

    segment_table_scoreboard sb;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: sample, then pick stall for next cycle
    int stall_left;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            i_out_stall <= 1;
            stall_left--;
        end else begin
            i_out_stall <= 0;
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // valid stays up after a transfer; send returns once the stall drops and the next item is set
    task automatic send(input t_in it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_transfer(it);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_SEGS + 8) @(posedge i_clk);
    endtask

    task automatic write_hotplug(input bit v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.hotplug_ok = v;
        i_cfg_valid <= 0;
    endtask

    function automatic t_in random_item();
        t_in it;
        logic [223:0] raw;
        int k;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        it.page_shift = 5'($urandom_range(12, 30));
        if ($urandom_range(0, 15) == 0) it.page_shift = 5'($urandom);
        k = $urandom_range(0, 99);
        if (k < 35) begin
            it.operation = OP_INSERT;
            it.seg_enabled = ($urandom_range(0, 9) != 0);
            it.seg_hotplug = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) begin
                it.seg_base = {8'($urandom_range(0, 3)), 40'($urandom_range(0, 63)) << 24};
                it.seg_length = 48'($urandom_range(1, 16)) << $urandom_range(12, 24);
            end
            if ($urandom_range(0, 29) == 0) it.seg_length = 0;
            if ($urandom_range(0, 29) == 0) it.seg_base = TOP48 - 48'($urandom_range(0, 4095));
        end else if (k < 38) begin
            it.operation = OP_CLEAR;
        end else if (k < 60) begin
            it.operation = OP_ADDR_TO_IDX;
            if ($urandom_range(0, 3) != 0)
                it.phys_addr = {8'($urandom_range(0, 3)), 40'($urandom) << $urandom_range(0, 8)};
        end else if (k < 82) begin
            it.operation = OP_IDX_TO_ADDR;
            if ($urandom_range(0, 3) != 0) it.page_index = 36'($urandom_range(0, 4095));
        end else if (k < 97) begin
            it.operation = OP_IS_LOCAL;
            if ($urandom_range(0, 3) != 0)
                it.phys_addr = {8'($urandom_range(0, 3)), 40'($urandom) << $urandom_range(0, 8)};
        end else begin
            it.operation = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    task automatic directed();
        t_in it;
        it = '0;
        it.operation = OP_IS_LOCAL;
        send(it);
        it.operation = OP_ADDR_TO_IDX;
        send(it);
        it.operation = OP_INSERT;
        it.seg_enabled = 1;
        it.seg_base = 48'h1000;
        it.seg_length = 48'h4000;
        it.seg_node = 4'd2;
        send(it);
        it.seg_length = 48'h2000;
        it.seg_node = 4'd15;
        send(it);
        it.seg_enabled = 0;
        send(it);
        it.seg_enabled = 1;
        it.seg_length = 0;
        send(it);
        it.seg_base = TOP48 - 48'hFFF;
        it.seg_length = TOP48;
        it.seg_node = 4'd0;
        it.seg_hotplug = 1;
        send(it);
        it.seg_base = 48'h10000;
        it.seg_length = 48'h1000;
        it.seg_hotplug = 0;
        send(it);
        it = '0;
        it.operation = OP_ADDR_TO_IDX;
        it.page_shift = 5'd12;
        it.phys_addr = 48'h1800;
        send(it);
        it.phys_addr = TOP48;
        send(it);
        it.page_shift = 5'd0;
        it.phys_addr = 48'h10FFF;
        send(it);
        it.operation = OP_IDX_TO_ADDR;
        it.target_node = 4'd2;
        it.page_index = 36'h3;
        it.page_shift = 5'd12;
        send(it);
        it.page_index = 36'hF_FFFF_FFFF;
        it.page_shift = 5'd31;
        send(it);
        it.page_shift = 5'd28;
        send(it);
        it.operation = OP_IS_LOCAL;
        it.phys_addr = 48'h4FFF;
        send(it);
        it.operation = 3'd7;
        send(it);
        it.operation = OP_CLEAR;
        send(it);
        it.operation = OP_IS_LOCAL;
        send(it);
    endtask

    initial begin
        t_in it;
        errors = 0;
        cycles = 0;
        quiet = 0;
        stall_left = 0;
        sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed();
        write_hotplug(0);
        it = '0;
        it.operation = OP_INSERT;
        it.seg_enabled = 1;
        it.seg_hotplug = 1;
        it.seg_length = 48'h1000;
        send(it);
        // fill past capacity
        for (int i = 0; i < MAX_SEGS + 2; i++) begin
            it.seg_hotplug = 0;
            it.seg_base = rand48();
            it.seg_length = 48'($urandom_range(1, 1 << 20));
            it.seg_node = 4'($urandom);
            send(it);
        end
        write_hotplug(1);
        for (int n = 0; n < 1700; n++) begin
            if (n == 600) write_hotplug(0);
            if (n == 1100) write_hotplug(1);
            if (n == 1400) quiet = 1;
            if (n % 250 == 249) drain();
            send(random_item());
        end
        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/nsat_pkg.sv
src/nsat_ctrl.sv
src/nsat_dp.sv
src/numa_segment_address_translator.sv
verif/numa_segment_address_translator_test.sv
